FILE: rtl/core/rbks_pkg.sv
package rbks_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DRAG_FRAC     = 8;
    localparam int TIME_FRAC     = 16;
    localparam int GRAVITY_UNITS = 30;
    localparam int SQRT_STEPS    = 32;

    // commands
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_FFORCE = 3'd1;
    localparam logic [2:0] CMD_IFORCE = 3'd2;
    localparam logic [2:0] CMD_STOPV  = 3'd3;
    localparam logic [2:0] CMD_STOPM  = 3'd4;

    // config register indexes
    localparam logic [2:0] REG_STAT  = 3'd0;
    localparam logic [2:0] REG_CHILD = 3'd1;
    localparam logic [2:0] REG_GRAV  = 3'd2;
    localparam logic [2:0] REG_HDRAG = 3'd3;
    localparam logic [2:0] REG_VDRAG = 3'd4;

    // datapath micro-ops
    localparam logic [4:0] U_NONE     = 5'd0;
    localparam logic [4:0] U_LOAD     = 5'd1;
    localparam logic [4:0] U_SQ       = 5'd2;
    localparam logic [4:0] U_SQACC    = 5'd3;
    localparam logic [4:0] U_SQRTINIT = 5'd4;
    localparam logic [4:0] U_SQRTSTEP = 5'd5;
    localparam logic [4:0] U_DIVINIT  = 5'd6;
    localparam logic [4:0] U_DIVSTEP  = 5'd7;
    localparam logic [4:0] U_DIVDONE  = 5'd8;
    localparam logic [4:0] U_FMUL     = 5'd9;
    localparam logic [4:0] U_FADDACC  = 5'd10;
    localparam logic [4:0] U_FADDVEL  = 5'd11;
    localparam logic [4:0] U_MPOS     = 5'd12;
    localparam logic [4:0] U_MMUL     = 5'd13;
    localparam logic [4:0] U_MSUB     = 5'd14;
    localparam logic [4:0] U_STOPV    = 5'd15;
    localparam logic [4:0] U_GRAV     = 5'd16;
    localparam logic [4:0] U_DMUL     = 5'd17;
    localparam logic [4:0] U_DSUB     = 5'd18;
    localparam logic [4:0] U_TV       = 5'd19;
    localparam logic [4:0] U_TVUSE    = 5'd20;
    localparam logic [4:0] U_TA2      = 5'd21;
    localparam logic [4:0] U_TA2USE   = 5'd22;
    localparam logic [4:0] U_TA       = 5'd23;
    localparam logic [4:0] U_TAUSE    = 5'd24;
    localparam logic [4:0] U_OUT      = 5'd25;

    typedef struct packed {
        logic        [2:0]  command;
        logic        [15:0] step_time;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] force_magnitude;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] ax;
    } t_uop;

    typedef struct packed {
        logic blocked;
        logic sum_zero;
        logic out_busy;
    } t_stat;

    // scale down by 2^k, truncating toward zero
    function automatic logic signed [65:0] f_trunc(input logic signed [65:0] p,
                                                   input int unsigned k);
        logic signed [65:0] bias;
        bias = (p < 0) ? ((66'sd1 <<< k) - 66'sd1) : 66'sd0;
        return (p + bias) >>> k;
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [67:0] s);
        if (s > 68'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (s < -68'sd2147483648)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    function automatic logic signed [32:0] f_abs(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return (w < 0) ? -w : w;
    endfunction

endpackage

FILE: rtl/core/rigid_body_kinematic_step.sv
// channel | direction | handshake           | beat
// input   | in        | i_valid / o_stall   | i_in  (command, step time, vector, magnitude)
// output  | out       | o_valid / i_stall   | o_out (position and velocity after the command)
// config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// One command at a time; o_stall is high from acceptance until the result is sent out.
// Blocked or unknown commands go straight to the output. A force squares each axis, takes a
// 32-step square root and runs three restoring divides on one shared unit, skipping both for a
// zero direction; stop momentum first moves the position, then does the same.
// Reset is synchronous; it clears the body state and the registers (gravity on).
// A finished beat waits in the output register; the next command is taken meanwhile.
module rigid_body_kinematic_step #(
    parameter int FRAC_BITS = rbks_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rbks_pkg::t_in    i_in,
    output logic             o_valid,
    input  logic             i_stall,
    output rbks_pkg::t_out   o_out,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data
);
    import rbks_pkg::*;

    t_uop  uop;
    t_stat stat;

    rbks_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_in.command),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_uop   (uop)
    );

    rbks_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_uop       (uop),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/core/rbks_ctrl.sv
module rbks_ctrl #(
    parameter int FRAC_BITS = rbks_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_cmd,
    output logic              o_stall,
    input  rbks_pkg::t_stat   i_stat,
    output rbks_pkg::t_uop    o_uop
);
    import rbks_pkg::*;

    localparam int MAXC = (FRAC_BITS > SQRT_STEPS) ? FRAC_BITS : SQRT_STEPS;
    localparam int CW   = $clog2(MAXC + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SQRTI = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_DIVI  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_DIVD  = 4'd6;
    localparam logic [3:0] S_APPLY = 4'd7;
    localparam logic [3:0] S_GRAV  = 4'd8;
    localparam logic [3:0] S_DRAG  = 4'd9;
    localparam logic [3:0] S_TICK  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [2:0]    r_cmd, n_cmd;
    logic [1:0]    r_ax, n_ax;
    logic [2:0]    r_ph, n_ph;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_TICK;
            r_ax    <= '0;
            r_ph    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_ax    <= n_ax;
            r_ph    <= n_ph;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_ax     = r_ax;
        n_ph     = r_ph;
        n_cnt    = r_cnt;
        o_uop.op = U_NONE;
        o_uop.ax = r_ax;
        unique case (r_state)
            S_IDLE: begin
                n_ax = '0;
                n_ph = '0;
                if (i_valid) begin
                    o_uop.op = U_LOAD;
                    n_cmd    = i_cmd;
                    case (i_cmd)
                        CMD_TICK:   n_state = i_stat.blocked ? S_OUT : S_GRAV;
                        CMD_FFORCE,
                        CMD_IFORCE: n_state = i_stat.blocked ? S_OUT : S_SQ;
                        CMD_STOPV:  n_state = S_APPLY;
                        CMD_STOPM:  n_state = S_APPLY;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_SQ: begin
                o_uop.op = r_ph[0] ? U_SQACC : U_SQ;
                n_ph     = {2'b00, ~r_ph[0]};
                if (r_ph[0]) begin
                    n_ax = r_ax + 2'd1;
                    if (r_ax == 2'd2) begin
                        n_ax    = '0;
                        n_state = S_SQRTI;
                    end
                end
            end
            S_SQRTI: begin
                if (i_stat.sum_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_uop.op = U_SQRTINIT;
                    n_cnt    = '0;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                o_uop.op = U_SQRTSTEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CW'(SQRT_STEPS - 1))
                    n_state = S_DIVI;
            end
            S_DIVI: begin
                o_uop.op = U_DIVINIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_uop.op = U_DIVSTEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CW'(FRAC_BITS - 1))
                    n_state = S_DIVD;
            end
            S_DIVD: begin
                o_uop.op = U_DIVDONE;
                n_ax     = r_ax + 2'd1;
                n_state  = S_DIVI;
                if (r_ax == 2'd2) begin
                    n_ax    = '0;
                    n_ph    = '0;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                // stop momentum: position first, then normalise, then push velocity
                case (r_cmd)
                    CMD_STOPV: begin
                        o_uop.op = U_STOPV;
                        n_state  = S_OUT;
                    end
                    CMD_STOPM: begin
                        if (r_ph == 3'd0) begin
                            o_uop.op = U_MPOS;
                            n_ph     = 3'd2;
                            n_state  = S_SQ;
                        end else begin
                            o_uop.op = r_ph[0] ? U_MSUB : U_MMUL;
                        end
                    end
                    default: begin
                        o_uop.op = r_ph[0] ? ((r_cmd == CMD_FFORCE) ? U_FADDACC : U_FADDVEL)
                                           : U_FMUL;
                    end
                endcase
                if (r_cmd != CMD_STOPV && !(r_cmd == CMD_STOPM && r_ph == 3'd0)) begin
                    // bit 1 marks a momentum push already normalised
                    n_ph = {1'b0, r_ph[1], ~r_ph[0]};
                    if (r_ph[0]) begin
                        n_ax = r_ax + 2'd1;
                        if (r_ax == 2'd2)
                            n_state = S_OUT;
                    end
                end
            end
            S_GRAV: begin
                o_uop.op = U_GRAV;
                n_ph     = '0;
                n_state  = S_DRAG;
            end
            S_DRAG: begin
                o_uop.op = r_ph[0] ? U_DSUB : U_DMUL;
                n_ph     = {2'b00, ~r_ph[0]};
                if (r_ph[0]) begin
                    n_ax = r_ax + 2'd1;
                    if (r_ax == 2'd2) begin
                        n_ax    = '0;
                        n_ph    = '0;
                        n_state = S_TICK;
                    end
                end
            end
            S_TICK: begin
                case (r_ph)
                    3'd0:    o_uop.op = U_TV;
                    3'd1:    o_uop.op = U_TVUSE;
                    3'd2:    o_uop.op = U_TA2;
                    3'd3:    o_uop.op = U_TA2USE;
                    3'd4:    o_uop.op = U_TA;
                    default: o_uop.op = U_TAUSE;
                endcase
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd5) begin
                    n_ph = '0;
                    n_ax = r_ax + 2'd1;
                    if (r_ax == 2'd2)
                        n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_uop.op = U_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // after the momentum position move, the phase marker returns to zero on the square loop
        if (r_state == S_APPLY && r_cmd == CMD_STOPM && r_ph == 3'd0)
            n_ph = '0;
        if (r_state == S_DIVD && r_ax == 2'd2)
            n_ph = (r_cmd == CMD_STOPM) ? 3'd2 : 3'd0;
    end

endmodule

FILE: rtl/core/rbks_dp.sv
module rbks_dp #(
    parameter int FRAC_BITS = rbks_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbks_pkg::t_in     i_in,
    input  rbks_pkg::t_uop    i_uop,
    output rbks_pkg::t_stat   o_stat,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output rbks_pkg::t_out    o_out
);
    import rbks_pkg::*;

    localparam int NW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;

    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_acc [3];
    logic signed [31:0] r_vec [3];
    logic signed [31:0] r_mag;
    logic        [15:0] r_dt;
    logic        [31:0] r_dtsq;
    logic               r_mom;
    logic signed [NW-1:0] r_n [3];

    logic r_stat, r_child, r_gon;
    logic [15:0] r_hdrag, r_vdrag;

    logic        [63:0] r_sum, r_rad, r_root, r_bit;
    logic        [33:0] r_rem;
    logic      [QW-1:0] r_q;
    logic signed [65:0] r_prod;
    logic signed [65:0] r_t1, r_t2;
    logic               r_ovalid;
    t_out               r_out;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [1:0]         ax;
    logic [32:0]        len;
    logic [63:0]        rb;
    logic [33:0]        dsh;
    logic [33:0]        vabs_u;

    assign ax  = i_uop.ax;
    assign len = r_root[32:0];
    assign rb  = r_root + r_bit;
    assign dsh = {r_rem[32:0], 1'b0};
    assign vabs_u = {1'b0, f_abs(r_vec[ax])};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_uop.op)
            U_SQ: begin
                mul_a = f_abs(r_vec[ax]);
                mul_b = f_abs(r_vec[ax]);
            end
            U_DMUL: begin
                mul_a = 33'(r_vel[ax]);
                mul_b = {17'd0, (ax == 2'd1) ? r_vdrag : r_hdrag};
            end
            U_FMUL: begin
                mul_a = 33'(r_n[ax]);
                mul_b = 33'(r_mag);
            end
            U_MMUL: begin
                mul_a = f_abs(r_vel[ax]);
                mul_b = 33'(r_n[ax]);
            end
            U_TV: begin
                mul_a = 33'(r_vel[ax]);
                mul_b = {17'd0, r_dt};
            end
            U_TA2: begin
                mul_a = 33'(r_acc[ax]);
                mul_b = {1'b0, r_dtsq};
            end
            U_TA: begin
                mul_a = 33'(r_acc[ax]);
                mul_b = {17'd0, r_dt};
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign o_stat.blocked  = r_stat | r_child;
    assign o_stat.sum_zero = (r_sum == 64'd0);
    assign o_stat.out_busy = r_ovalid & i_stall;
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat   <= 1'b0;
            r_child  <= 1'b0;
            r_gon    <= 1'b1;
            r_hdrag  <= '0;
            r_vdrag  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STAT:  r_stat  <= i_cfg_data[0];
                REG_CHILD: r_child <= i_cfg_data[0];
                REG_GRAV:  r_gon   <= i_cfg_data[0];
                REG_HDRAG: r_hdrag <= i_cfg_data;
                REG_VDRAG: r_vdrag <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_uop.op == U_OUT) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_acc[i] <= '0;
            end
        end else begin
            unique case (i_uop.op)
                U_FADDACC: r_acc[ax] <= f_sat(68'(r_acc[ax]) + 68'(f_trunc(r_prod, FRAC_BITS)));
                U_FADDVEL: r_vel[ax] <= f_sat(68'(r_vel[ax]) + 68'(f_trunc(r_prod, FRAC_BITS)));
                U_MPOS: begin
                    for (int i = 0; i < 3; i++)
                        r_pos[i] <= f_sat(68'(r_pos[i]) + 68'(r_vec[i]));
                end
                U_MSUB: r_vel[ax] <= f_sat(68'(r_vel[ax]) - 68'(f_trunc(r_prod, FRAC_BITS)));
                U_STOPV: begin
                    for (int i = 0; i < 3; i++)
                        r_vel[i] <= '0;
                end
                U_GRAV: begin
                    if (r_gon)
                        r_acc[1] <= f_sat(68'(r_acc[1])
                                          - (68'(GRAVITY_UNITS) <<< FRAC_BITS));
                end
                U_DSUB: begin
                    // vertical drag only acts on upward motion
                    if (ax != 2'd1 || r_vel[1] > 0)
                        r_acc[ax] <= f_sat(68'(r_acc[ax]) - 68'(f_trunc(r_prod, DRAG_FRAC)));
                end
                U_TAUSE: begin
                    r_pos[ax] <= f_sat(68'(r_pos[ax]) + 68'(r_t1) + 68'(r_t2));
                    r_vel[ax] <= f_sat(68'(r_vel[ax]) + 68'(f_trunc(r_prod, TIME_FRAC)));
                    r_acc[ax] <= '0;
                end
                default: ;
            endcase
        end
    end

    // working registers: no reset
    always_ff @(posedge i_clk) begin
        if (i_uop.op == U_SQ || i_uop.op == U_DMUL || i_uop.op == U_FMUL ||
            i_uop.op == U_MMUL || i_uop.op == U_TV || i_uop.op == U_TA2 ||
            i_uop.op == U_TA)
            r_prod <= mul_p;
        case (i_uop.op)
            U_LOAD: begin
                r_vec[0] <= i_in.vec_x;
                r_vec[1] <= i_in.vec_y;
                r_vec[2] <= i_in.vec_z;
                r_mag    <= i_in.force_magnitude;
                r_dt     <= i_in.step_time;
                r_dtsq   <= 32'(i_in.step_time) * 32'(i_in.step_time);
                r_mom    <= (i_in.command == CMD_STOPM);
                r_sum    <= '0;
            end
            U_SQACC: r_sum <= r_sum + r_prod[63:0];
            U_SQRTINIT: begin
                r_rad  <= r_sum;
                r_root <= '0;
                r_bit  <= 64'd1 << 62;
            end
            U_SQRTSTEP: begin
                if (r_rad >= rb) begin
                    r_rad  <= r_rad - rb;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            U_DIVINIT: begin
                // magnitude never exceeds the length, so the top bit settles at once
                if (vabs_u >= {1'b0, len}) begin
                    r_rem <= vabs_u - {1'b0, len};
                    r_q   <= QW'(1);
                end else begin
                    r_rem <= vabs_u;
                    r_q   <= '0;
                end
            end
            U_DIVSTEP: begin
                if (dsh >= {1'b0, len}) begin
                    r_rem <= dsh - {1'b0, len};
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= dsh;
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
            end
            U_DIVDONE: begin
                // momentum normalises the negated offset
                if (r_mom ? (r_vec[ax] > 0) : (r_vec[ax] < 0))
                    r_n[ax] <= -$signed({1'b0, r_q});
                else
                    r_n[ax] <= $signed({1'b0, r_q});
            end
            U_TVUSE:  r_t1 <= f_trunc(r_prod, TIME_FRAC);
            U_TA2USE: r_t2 <= f_trunc(r_prod, 2 * TIME_FRAC + 1);
            U_OUT: begin
                r_out.pos_x <= r_pos[0];
                r_out.pos_y <= r_pos[1];
                r_out.pos_z <= r_pos[2];
                r_out.vel_x <= r_vel[0];
                r_out.vel_y <= r_vel[1];
                r_out.vel_z <= r_vel[2];
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/rbks_chk.sv
module rbks_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input rbks_pkg::t_out o_out
);
    import rbks_pkg::*;

    a_rst_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("no busy after accepted beat");

    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result shown while still busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled output beat changed");

endmodule

bind rigid_body_kinematic_step rbks_chk u_rbks_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rbks_pkg::*;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam int N_RANDOM = 400;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_in;
    logic        o_valid;
    logic        i_stall;
    t_out        o_out;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    rigid_body_kinematic_step i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    int n_errors;
    longint cycles;
    int n_beats_in, n_beats_out;
    int rx_mode;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("mismatch %s: got %h want %h (beat %0d)", what, got, exp, n_beats_out);
        n_errors++;
    endtask

    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // truncating division by 2^k
    function automatic longint shr_tz(input longint v, input int k);
        longint d;
        d = 64'sd1 << k;
        return v / d;
    endfunction

    function automatic longint isqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    class body_scoreboard;
        longint pos[3], vel[3], acc[3];
        bit stat, child, grav;
        longint hdrag, vdrag;
        t_out pending[$];

        function void clear();
            for (int i = 0; i < 3; i++) begin
                pos[i] = 0; vel[i] = 0; acc[i] = 0;
            end
            stat = 0; child = 0; grav = 1; hdrag = 0; vdrag = 0;
            pending.delete();
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [15:0] d);
            case (idx)
                REG_STAT:  stat = d[0];
                REG_CHILD: child = d[0];
                REG_GRAV:  grav = d[0];
                REG_HDRAG: hdrag = d;
                REG_VDRAG: vdrag = d;
                default: ;
            endcase
        endfunction

        // unit vector; returns 0 for a zero vector
        function bit unit_vec(input longint v[3], output longint n[3]);
            longint unsigned s;
            longint len;
            s = 0;
            for (int i = 0; i < 3; i++) s += longint'(v[i] * v[i]);
            for (int i = 0; i < 3; i++) n[i] = 0;
            if (s == 0) return 0;
            len = isqrt(s);
            for (int i = 0; i < 3; i++) n[i] = (v[i] * ONE) / len;
            return 1;
        endfunction

        function void note_command(input t_in c);
            longint v[3], n[3], neg[3], m, a, t1, t2, dt, av;
            bit blocked;
            t_out r;
            blocked = stat | child;
            v[0] = c.vec_x; v[1] = c.vec_y; v[2] = c.vec_z;
            m = c.force_magnitude;
            dt = c.step_time;
            if (c.command == CMD_TICK && !blocked) begin
                if (grav) acc[1] = sat(acc[1] - (64'sd30 << FB));
                acc[0] = sat(acc[0] - shr_tz(vel[0] * hdrag, 8));
                acc[2] = sat(acc[2] - shr_tz(vel[2] * hdrag, 8));
                if (vel[1] > 0) acc[1] = sat(acc[1] - shr_tz(vel[1] * vdrag, 8));
                for (int i = 0; i < 3; i++) begin
                    a = acc[i];
                    t1 = shr_tz(vel[i] * dt, 16);
                    // a*dt*dt can reach 2^63, so it is formed wider
                    t2 = shr_tz_big(a, dt * dt);
                    pos[i] = sat(pos[i] + t1 + t2);
                    vel[i] = sat(vel[i] + shr_tz(a * dt, 16));
                    acc[i] = 0;
                end
            end else if ((c.command == CMD_FFORCE || c.command == CMD_IFORCE) && !blocked) begin
                if (unit_vec(v, n)) begin
                    for (int i = 0; i < 3; i++) begin
                        if (c.command == CMD_FFORCE)
                            acc[i] = sat(acc[i] + (n[i] * m) / ONE);
                        else
                            vel[i] = sat(vel[i] + (n[i] * m) / ONE);
                    end
                end
            end else if (c.command == CMD_STOPV) begin
                for (int i = 0; i < 3; i++) vel[i] = 0;
            end else if (c.command == CMD_STOPM) begin
                for (int i = 0; i < 3; i++) begin
                    pos[i] = sat(pos[i] + v[i]);
                    neg[i] = -v[i];
                end
                if (unit_vec(neg, n)) begin
                    for (int i = 0; i < 3; i++) begin
                        av = vel[i] < 0 ? -vel[i] : vel[i];
                        vel[i] = sat(vel[i] - (av * n[i]) / ONE);
                    end
                end
            end
            r.pos_x = 32'(pos[0]); r.pos_y = 32'(pos[1]); r.pos_z = 32'(pos[2]);
            r.vel_x = 32'(vel[0]); r.vel_y = 32'(vel[1]); r.vel_z = 32'(vel[2]);
            pending.push_back(r);
        endfunction

        // a * q / 2^33 with truncation, a up to 2^31 and q up to 2^32
        function longint shr_tz_big(input longint a, input longint q);
            logic signed [95:0] p;
            logic signed [95:0] d;
            p = 96'(a) * 96'(q);
            d = 96'sd1 <<< 33;
            return longint'(p / d);
        endfunction

        task check_beat(input t_out got);
            t_out w;
            if (pending.size() == 0) begin
                $display("unexpected beat %0d", n_beats_out);
                n_errors++;
                return;
            end
            w = pending.pop_front();
            if (got.pos_x !== w.pos_x) report_mismatch("pos_x", got.pos_x, w.pos_x);
            if (got.pos_y !== w.pos_y) report_mismatch("pos_y", got.pos_y, w.pos_y);
            if (got.pos_z !== w.pos_z) report_mismatch("pos_z", got.pos_z, w.pos_z);
            if (got.vel_x !== w.vel_x) report_mismatch("vel_x", got.vel_x, w.vel_x);
            if (got.vel_y !== w.vel_y) report_mismatch("vel_y", got.vel_y, w.vel_y);
            if (got.vel_z !== w.vel_z) report_mismatch("vel_z", got.vel_z, w.vel_z);
        endtask
    endclass

    body_scoreboard sb;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver stall pattern and output check
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_beat(o_out);
            n_beats_out <= n_beats_out + 1;
        end
        if (i_rst_n && i_valid && !o_stall) n_beats_in <= n_beats_in + 1;
        case (rx_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
        if ($urandom_range(0, 199) == 0) rx_mode <= $urandom_range(0, 2);
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_cmd(input t_in c);
        i_valid <= 1'b1;
        i_in <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_command(c);
    endtask

    task automatic idle_send(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, d);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'sd0;
            3: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sd32768);
            4: return 32'($signed($urandom_range(0, 24'hFFFFFF)) - 32'sd8388608);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rnd_cmd();
        t_in c;
        int k;
        k = $urandom_range(0, 19);
        if (k < 7) c.command = CMD_TICK;
        else if (k < 11) c.command = CMD_FFORCE;
        else if (k < 15) c.command = CMD_IFORCE;
        else if (k < 16) c.command = CMD_STOPV;
        else if (k < 19) c.command = CMD_STOPM;
        else c.command = 3'($urandom_range(5, 7));
        c.step_time = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        c.vec_x = rnd_word();
        c.vec_y = rnd_word();
        c.vec_z = rnd_word();
        c.force_magnitude = rnd_word();
        return c;
    endfunction

    function automatic t_in mk(input logic [2:0] op, input logic [15:0] dt,
                               input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] m);
        t_in c;
        c.command = op; c.step_time = dt;
        c.vec_x = x; c.vec_y = y; c.vec_z = z; c.force_magnitude = m;
        return c;
    endfunction

    task automatic set_regs(input bit st, input bit ch, input bit gr,
                            input logic [15:0] hd, input logic [15:0] vd);
        write_reg(REG_STAT, {15'd0, st});
        write_reg(REG_CHILD, {15'd0, ch});
        write_reg(REG_GRAV, {15'd0, gr});
        write_reg(REG_HDRAG, hd);
        write_reg(REG_VDRAG, vd);
    endtask

    initial begin
        int sent;
        sb = new();
        sb.clear();
        n_errors = 0; cycles = 0; n_beats_in = 0; n_beats_out = 0; rx_mode = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_in = '0; i_stall = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_cmd(mk(CMD_TICK, 16'hFFFF, 0, 0, 0, 0));
        send_cmd(mk(CMD_TICK, 16'h0000, 0, 0, 0, 0));
        send_cmd(mk(CMD_IFORCE, 0, 32'h0001_0000, 0, 0, 32'h0050_0000));
        send_cmd(mk(CMD_IFORCE, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_cmd(mk(CMD_FFORCE, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000));
        send_cmd(mk(CMD_FFORCE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF));
        send_cmd(mk(CMD_TICK, 16'h8000, 32'hFFFF_FFFF, 0, 0, 0));
        send_cmd(mk(CMD_STOPM, 0, 0, 0, 0, 0));
        send_cmd(mk(CMD_STOPM, 0, 32'h0003_0000, 32'hFFFC_0000, 0, 0));
        send_cmd(mk(CMD_STOPV, 0, 32'h1234, 0, 0, 0));
        send_cmd(mk(CMD_STOPM, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_cmd(mk(3'd5, 16'h1, 1, 1, 1, 1));
        send_cmd(mk(3'd7, 16'h1, 1, 1, 1, 1));
        drain();
        set_regs(1, 0, 0, 16'hFFFF, 16'hFFFF);
        send_cmd(mk(CMD_TICK, 16'hFFFF, 0, 0, 0, 0));
        send_cmd(mk(CMD_IFORCE, 0, 1, 0, 0, 32'h0010_0000));
        send_cmd(mk(CMD_STOPM, 0, 1, 2, 3, 0));
        drain();
        set_regs(0, 1, 1, 16'h0100, 16'h0080);
        send_cmd(mk(CMD_FFORCE, 0, 1, 0, 0, 32'h0010_0000));
        send_cmd(mk(CMD_STOPV, 0, 0, 0, 0, 0));
        drain();
        set_regs(0, 0, 1, 16'hFFFF, 16'hFFFF);
        send_cmd(mk(CMD_IFORCE, 0, 0, 1, 0, 32'h0100_0000));
        send_cmd(mk(CMD_TICK, 16'h4000, 0, 0, 0, 0));
        send_cmd(mk(CMD_IFORCE, 0, 1, 0, 1, 32'h7FFF_FFFF));
        send_cmd(mk(CMD_TICK, 16'hFFFF, 0, 0, 0, 0));
        drain();

        // random, in bursts; registers change between phases
        sent = 0;
        while (sent < N_RANDOM) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                send_cmd(rnd_cmd());
                sent++;
            end
            if ($urandom_range(0, 2) == 0) idle_send($urandom_range(1, 60));
            if (sent % 80 < burst) begin
                // hold off until every result is back, then reconfigure
                drain();
                set_regs($urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                         $urandom_range(0, 1),
                         ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 600)),
                         ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
                if ($urandom_range(0, 1) == 0)
                    send_cmd(mk(CMD_STOPV, 0, 0, 0, 0, 0));
            end
        end
        drain();
        repeat (200) @(posedge i_clk);

        $display("ran %0d commands over %0d cycles, %0d results checked",
                 n_beats_in, cycles, n_beats_out);
        $display("all five commands, blocked body, drag and register extremes covered");
        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d results outstanding", n_errors, sb.pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
